// File: hw/rtl/htfc_pkg.sv
// Shared types, constants and the CRC-8 byte step for the frame checker.
// No dependencies; every other file except htfc_if imports this package.
`default_nettype none

package htfc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Frame byte positions
    localparam logic [2:0] POS_TEMP_MSB  = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC  = 3'd2;
    localparam logic [2:0] POS_HUMID_MSB = 3'd3;
    localparam logic [2:0] POS_HUMID_LSB = 3'd4;
    localparam logic [2:0] POS_HUMID_CRC = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC  = 2'd1;
    localparam logic [1:0] STATUS_HUMID_CRC = 2'd2;

    // Conversion constants: value = offset + floor(scale * raw / 65535)
    localparam logic [15:0] TEMP_OFFSET = 16'd22815;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUMID_SCALE = 14'd10000;
    localparam logic [15:0] TEMP_MAX    = 16'd40315;
    localparam logic [13:0] HUMID_MAX   = 14'd10000;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } frame_rec_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/htfc_if.sv
// Valid/ready channel interfaces: byte input and converted result output.
// No dependencies.
`default_nettype none

interface htfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source(output valid, output rx_byte, output frame_start, input ready);
    modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
    logic [15:0] temp_centikelvin;
    logic [13:0] humid_centipercent;

    modport source(output valid, output frame_status, output temp_raw, output humid_raw,
                   output temp_centikelvin, output humid_centipercent, input ready);
    modport sink(input valid, input frame_status, input temp_raw, input humid_raw,
                 input temp_centikelvin, input humid_centipercent, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/htfc_front.sv
// Front end: tracks byte position, runs the CRC, assembles frame records.
// Depends on htfc_pkg and htfc_byte_if.
`default_nettype none

module htfc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    htfc_byte_if.sink               byte_in,
    output logic                    push,
    output htfc_pkg::frame_rec_t    rec,
    input  wire logic               q_ready
);
    import htfc_pkg::*;

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  humid_high_reg, humid_high_next;
    logic [7:0]  humid_low_reg, humid_low_next;
    logic        temp_good_reg, temp_good_next;

    logic        accept;
    logic [2:0]  pos;
    logic [7:0]  crc_step;

    assign byte_in.ready = q_ready;
    assign accept        = byte_in.valid & q_ready;
    assign crc_step      = crc_byte((pos == POS_TEMP_LSB || pos == POS_HUMID_LSB)
                                    ? crc_reg : CRC_INIT, byte_in.rx_byte);

    always_comb
    begin
        pos = byte_in.frame_start ? POS_TEMP_MSB : byte_count_reg;
        if (pos > POS_HUMID_CRC)
            pos = POS_TEMP_MSB;
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        temp_word_next  = temp_word_reg;
        humid_high_next = humid_high_reg;
        humid_low_next  = humid_low_reg;
        temp_good_next  = temp_good_reg;
        push            = 1'b0;
        rec.status      = STATUS_OK;
        rec.temp_raw    = temp_word_reg;
        rec.humid_raw   = {humid_high_reg, humid_low_reg};
        if (!temp_good_reg)
            rec.status = STATUS_TEMP_CRC;
        else if (crc_reg != byte_in.rx_byte)
            rec.status = STATUS_HUMID_CRC;
        if (accept)
        begin
            byte_count_next = pos + 3'd1;
            unique case (pos)
                POS_TEMP_MSB:
                begin
                    crc_next       = crc_step;
                    temp_word_next = {byte_in.rx_byte, 8'h00};
                end
                POS_TEMP_LSB:
                begin
                    crc_next       = crc_step;
                    temp_word_next = {temp_word_reg[15:8], byte_in.rx_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_good_next = (crc_reg == byte_in.rx_byte);
                    crc_next       = CRC_INIT;
                end
                POS_HUMID_MSB:
                begin
                    crc_next        = crc_step;
                    humid_high_next = byte_in.rx_byte;
                end
                POS_HUMID_LSB:
                begin
                    crc_next       = crc_step;
                    humid_low_next = byte_in.rx_byte;
                end
                default:
                begin
                    // sixth byte: emit the record and wrap the count
                    push            = 1'b1;
                    crc_next        = CRC_INIT;
                    byte_count_next = POS_TEMP_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= POS_TEMP_MSB;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= '0;
            humid_high_reg <= '0;
            humid_low_reg  <= '0;
            temp_good_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            temp_word_reg  <= temp_word_next;
            humid_high_reg <= humid_high_next;
            humid_low_reg  <= humid_low_next;
            temp_good_reg  <= temp_good_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/htfc_queue.sv
// Short record queue between the front end and the conversion back end.
// Depends on htfc_pkg.
`default_nettype none

module htfc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  htfc_pkg::frame_rec_t    push_rec,
    output logic                    not_full,
    output logic                    pop_valid,
    output htfc_pkg::frame_rec_t    pop_rec,
    input  wire logic               pop_ready
);
    import htfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = mem[rd_ptr_reg];
    assign do_push   = push & not_full;
    assign do_pop    = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/htfc_back.sv
// Back end: two-stage conversion pipeline (scale multiply, divide by 65535)
// feeding the result register. Depends on htfc_pkg and htfc_result_if.
`default_nettype none

module htfc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  htfc_pkg::frame_rec_t    q_rec,
    output logic                    q_ready,
    htfc_result_if.source           result_out
);
    import htfc_pkg::*;

    logic        s1_valid_reg;
    frame_rec_t  s1_rec_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_traw_reg;
    logic [15:0] out_hraw_reg;
    logic [15:0] out_tck_reg;
    logic [13:0] out_hcp_reg;

    logic        out_adv, s1_adv;
    logic [31:0] tsum, hsum;
    logic [15:0] tck_next;
    logic [13:0] hcp_next;

    assign out_adv = !out_valid_reg | result_out.ready;
    assign s1_adv  = !s1_valid_reg | out_adv;
    assign q_ready = s1_adv;

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for the quotients seen here
    assign tsum = {1'b0, s1_tprod_reg} + 32'(s1_tprod_reg[30:16]) + 32'd1;
    assign hsum = {2'b00, s1_hprod_reg} + 32'(s1_hprod_reg[29:16]) + 32'd1;

    always_comb
    begin
        tck_next = '0;
        hcp_next = '0;
        if (s1_rec_reg.status == STATUS_OK)
        begin
            tck_next = TEMP_OFFSET + tsum[31:16];
            hcp_next = hsum[29:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && q_valid)
        begin
            s1_rec_reg   <= q_rec;
            s1_tprod_reg <= 31'(q_rec.temp_raw) * 31'(TEMP_SCALE);
            s1_hprod_reg <= 30'(q_rec.humid_raw) * 30'(HUMID_SCALE);
        end
        if (out_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_rec_reg.status;
            out_traw_reg   <= s1_rec_reg.temp_raw;
            out_hraw_reg   <= s1_rec_reg.humid_raw;
            out_tck_reg    <= tck_next;
            out_hcp_reg    <= hcp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= q_valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.frame_status       = out_status_reg;
    assign result_out.temp_raw           = out_traw_reg;
    assign result_out.humid_raw          = out_hraw_reg;
    assign result_out.temp_centikelvin   = out_tck_reg;
    assign result_out.humid_centipercent = out_hcp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/humidity_temp_frame_check_convert.sv
// Sensor frame checker: one byte accepted per cycle while the queue has room; one result per six-byte frame.
// Path: the sixth byte's record is written to the queue, then registered in the
// scale-multiply stage, then in the divide/offset stage that drives the result.
// Throughput: one byte every cycle; input stalls only when the two-entry queue is full.
// Reset (rst_n, async, active low) clears the byte count, CRC, queue and pipeline valids.
// Depends on htfc_pkg, htfc_if, htfc_front, htfc_queue, htfc_back.
`default_nettype none

module humidity_temp_frame_check_convert (
    input  wire logic       clk,
    input  wire logic       rst_n,
    htfc_byte_if.sink       byte_in,
    htfc_result_if.source   result_out
);
    import htfc_pkg::*;

    logic       push;
    logic       q_not_full;
    logic       q_valid;
    logic       q_ready;
    frame_rec_t push_rec;
    frame_rec_t q_rec;

    htfc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .push    (push),
        .rec     (push_rec),
        .q_ready (q_not_full)
    );

    htfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .not_full  (q_not_full),
        .pop_valid (q_valid),
        .pop_rec   (q_rec),
        .pop_ready (q_ready)
    );

    htfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_rec      (q_rec),
        .q_ready    (q_ready),
        .result_out (result_out)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.frame_status != STATUS_OK) |->
        (result_out.temp_centikelvin == '0 && result_out.humid_centipercent == '0))
        else $error("converted fields nonzero on CRC error");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.frame_status == STATUS_OK) |->
        (result_out.temp_centikelvin >= TEMP_OFFSET && result_out.temp_centikelvin <= TEMP_MAX
         && result_out.humid_centipercent <= HUMID_MAX))
        else $error("converted value out of range");

    a_push_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!byte_in.frame_start && q_not_full))
        else $error("record pushed on a frame start byte or into a full queue");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (q_rec.status == STATUS_OK || q_rec.status == STATUS_TEMP_CRC
                     || q_rec.status == STATUS_HUMID_CRC))
        else $error("queued record holds an unknown status");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for humidity_temp_frame_check_convert: byte stream in, checked
// frames out, predicted by a scoreboard class. Depends on htfc_pkg, htfc_if and the RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import htfc_pkg::*;

    localparam int RANDOM_BYTES   = 1200;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        logic [15:0] temp_ck;
        logic [13:0] humid_cp;
    } frame_result_t;

    class frame_scoreboard;
        frame_result_t expected_frames[$];
        int            errors;
        int            checked;
        int            status_seen[3];

        // frame decode state, mirrors the block
        logic [2:0]    byte_pos;
        logic [7:0]    crc_run;
        logic [15:0]   temp_word;
        logic [7:0]    humid_msb;
        logic [7:0]    humid_lsb;
        logic          temp_ok;

        function new();
            byte_pos  = POS_TEMP_MSB;
            crc_run   = CRC_INIT;
            temp_word = '0;
            humid_msb = '0;
            humid_lsb = '0;
            temp_ok   = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        // CRC-8 over one byte, bit-serial form of polynomial 0x31
        function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void absorb_byte(logic [7:0] b, logic start);
            logic [2:0]    pos;
            frame_result_t res;
            int unsigned   traw;
            int unsigned   hraw;
            pos = start ? POS_TEMP_MSB : byte_pos;
            if (pos > POS_HUMID_CRC)
                pos = POS_TEMP_MSB;
            case (pos)
                POS_TEMP_MSB:
                begin
                    crc_run   = crc_step(CRC_INIT, b);
                    temp_word = {b, 8'h00};
                end
                POS_TEMP_LSB:
                begin
                    crc_run   = crc_step(crc_run, b);
                    temp_word = {temp_word[15:8], b};
                end
                POS_TEMP_CRC:
                begin
                    temp_ok = (crc_run == b);
                    crc_run = CRC_INIT;
                end
                POS_HUMID_MSB:
                begin
                    crc_run   = crc_step(CRC_INIT, b);
                    humid_msb = b;
                end
                POS_HUMID_LSB:
                begin
                    crc_run   = crc_step(crc_run, b);
                    humid_lsb = b;
                end
                default:
                begin
                    traw = 32'(temp_word);
                    hraw = 32'({humid_msb, humid_lsb});
                    res.temp_raw  = temp_word;
                    res.humid_raw = {humid_msb, humid_lsb};
                    res.temp_ck   = '0;
                    res.humid_cp  = '0;
                    if (!temp_ok)
                        res.status = STATUS_TEMP_CRC;
                    else if (crc_run != b)
                        res.status = STATUS_HUMID_CRC;
                    else
                        res.status = STATUS_OK;
                    if (res.status == STATUS_OK)
                    begin
                        res.temp_ck  = 16'(32'(TEMP_OFFSET) + (32'(TEMP_SCALE) * traw) / 32'd65535);
                        res.humid_cp = 14'((32'(HUMID_SCALE) * hraw) / 32'd65535);
                    end
                    expected_frames.push_back(res);
                    crc_run = CRC_INIT;
                end
            endcase
            byte_pos = (pos == POS_HUMID_CRC) ? POS_TEMP_MSB : pos + 3'd1;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(frame_result_t got);
            frame_result_t exp;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d temp_raw=%h humid_raw=%h",
                                 got.status, got.temp_raw, got.humid_raw));
                return;
            end
            exp = expected_frames.pop_front();
            checked++;
            if (got.status <= STATUS_HUMID_CRC)
                status_seen[got.status]++;
            if (got.status !== exp.status)
                report($sformatf("frame_status got %0d want %0d", got.status, exp.status));
            if (got.temp_raw !== exp.temp_raw)
                report($sformatf("temp_raw got %h want %h", got.temp_raw, exp.temp_raw));
            if (got.humid_raw !== exp.humid_raw)
                report($sformatf("humid_raw got %h want %h", got.humid_raw, exp.humid_raw));
            if (got.temp_ck !== exp.temp_ck)
                report($sformatf("temp_centikelvin got %0d want %0d (raw %h)",
                                 got.temp_ck, exp.temp_ck, exp.temp_raw));
            if (got.humid_cp !== exp.humid_cp)
                report($sformatf("humid_centipercent got %0d want %0d (raw %h)",
                                 got.humid_cp, exp.humid_cp, exp.humid_raw));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    htfc_byte_if   byte_ch();
    htfc_result_if result_ch();

    humidity_temp_frame_check_convert u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    frame_scoreboard sb = new();

    int bytes_sent = 0;
    int hold_req   = 0;
    bit no_idle    = 1'b0;
    int idle_count = 0;

    always #5 clk = ~clk;

    initial
    begin
        byte_ch.valid       = 1'b0;
        byte_ch.rx_byte     = '0;
        byte_ch.frame_start = 1'b0;
        result_ch.ready     = 1'b0;
    end

    // Abort when neither side has moved a transfer for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", idle_count);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold when requested
    initial
    begin
        int            stall;
        frame_result_t got;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            got.status    = result_ch.frame_status;
            got.temp_raw  = result_ch.temp_raw;
            got.humid_raw = result_ch.humid_raw;
            got.temp_ck   = result_ch.temp_centikelvin;
            got.humid_cp  = result_ch.humid_centipercent;
            sb.check_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.rx_byte     <= b;
        byte_ch.frame_start <= start;
        do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
        sb.absorb_byte(b, start);
        bytes_sent++;
    endtask

    // Send the first n bytes of a frame; a nonzero mask corrupts that CRC byte
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic start,
                              input logic [7:0] t_mask, input logic [7:0] h_mask,
                              input int n = 6);
        logic [7:0] fb[6];
        fb[0] = t[15:8];
        fb[1] = t[7:0];
        fb[2] = sb.crc_step(sb.crc_step(CRC_INIT, t[15:8]), t[7:0]) ^ t_mask;
        fb[3] = h[15:8];
        fb[4] = h[7:0];
        fb[5] = sb.crc_step(sb.crc_step(CRC_INIT, h[15:8]), h[7:0]) ^ h_mask;
        for (int i = 0; i < n; i++)
            send_byte(fb[i], (i == 0) ? start : 1'b0);
    endtask

    // Hold the input until every outstanding frame has come back
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() > 0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'hFFFE;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        int  kind;
        int  rand_start;
        int  n;
        bit  need_start;
        bit  held;
        bit  paused;
        logic [7:0] t_mask;
        logic [7:0] h_mask;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, back-to-back, dropped partial, both error kinds
        send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 8'h00, 8'h00, 2);
        send_frame(16'h6666, 16'h9999, 1'b1, 8'hFF, 8'h01);
        send_frame(16'h5A5A, 16'hA5A5, 1'b1, 8'h00, 8'h80);
        drain_results();

        rand_start = bytes_sent;
        need_start = 1'b1;
        held       = 1'b0;
        paused     = 1'b0;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            n = bytes_sent - rand_start;
            no_idle = (n >= 600 && n < 800);
            if (!held && n >= 300)
            begin
                // result side stops while frames keep coming, so the input backs up
                hold_req = HOLD_CYCLES;
                held     = 1'b1;
            end
            if (!paused && n >= 900)
            begin
                drain_results();
                paused = 1'b1;
            end

            kind   = $urandom_range(0, 99);
            t_mask = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
            h_mask = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
            if (kind < 85)
            begin
                send_frame(pick_word(), pick_word(), need_start | 1'($urandom_range(0, 1)),
                           t_mask, h_mask);
                need_start = 1'b0;
            end
            else if (kind < 93)
            begin
                // broken frame: cut short, the next one resyncs with a start flag
                send_frame(pick_word(), pick_word(), 1'b1, t_mask, h_mask,
                           $urandom_range(1, 5));
                need_start = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom()), ($urandom_range(0, 3) == 0));
                need_start = 1'b1;
            end
        end
        no_idle = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes; checked %0d frames: %0d ok, %0d temp crc, %0d humid crc",
                 bytes_sent, sb.checked, sb.status_seen[0], sb.status_seen[1],
                 sb.status_seen[2]);
        $display("covered back-to-back and resynced frames, noise bytes, long output hold");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
